### rtl/core/rrds_pkg.sv
// shared types and constants for the round robin demoting scheduler
`default_nettype none
package rrds_pkg;
  localparam int MAX_ENTRIES_DEF = 16;
  localparam int WAIT_DEPTH_DEF  = 16;

  typedef enum logic [1:0] {
    OP_ADMIT    = 2'd0,
    OP_KILL     = 2'd1,
    OP_DISPATCH = 2'd2,
    OP_NONE     = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    EV_ADMITTED  = 4'd0,
    EV_WAITING   = 4'd1,
    EV_REJECTED  = 4'd2,
    EV_KILL_ACT  = 4'd3,
    EV_KILL_WAIT = 4'd4,
    EV_NOT_FOUND = 4'd5,
    EV_EXPIRED   = 4'd6,
    EV_DEMOTED   = 4'd7,
    EV_FINISHED  = 4'd8,
    EV_IDLE      = 4'd9
  } ev_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_SRCH_A,
    ST_SRCH_W,
    ST_SHIFT_A,
    ST_SHIFT_W,
    ST_OUT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture input item
    logic decide;    // perform admit / dispatch step or start a kill
    logic srch_a;    // compare one active entry
    logic srch_w;    // compare one waiting entry
    logic shift_a;   // move one active entry up
    logic shift_w;   // move one waiting entry up
    logic finish_a;  // close an active removal
    logic finish_w;  // close a waiting removal
    logic not_found; // kill found nothing
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_kill;
    logic remove;    // decide step needs active removal
    logic a_hit;     // active entry at scan pointer matches
    logic w_hit;     // waiting entry at scan pointer matches
    logic a_last;    // active pointer at end of table
    logic w_last;    // waiting pointer at end of table
  } sts_t;

  localparam logic [3:0] CFG_QUANTUM = 4'd0;
  localparam logic [3:0] CFG_DEMOTE  = 4'd4;
  localparam logic [3:0] CFG_ACTIVE  = 4'd8;
endpackage
`default_nettype wire

### rtl/core/rrds_ctrl.sv
// sequencer for admit, kill and dispatch requests
`default_nettype none
module rrds_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  wire logic          out_stall,
  input  wire rrds_pkg::sts_t sts,
  output rrds_pkg::cmd_t     cmd
);
  rrds_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= rrds_pkg::ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rrds_pkg::ST_IDLE:   if (in_valid) state_nxt = rrds_pkg::ST_DECIDE;
      rrds_pkg::ST_DECIDE: begin
        if (sts.is_kill)     state_nxt = rrds_pkg::ST_SRCH_A;
        else if (sts.remove) state_nxt = rrds_pkg::ST_SHIFT_A;
        else                 state_nxt = rrds_pkg::ST_OUT;
      end
      rrds_pkg::ST_SRCH_A: begin
        if (sts.a_hit)       state_nxt = rrds_pkg::ST_SHIFT_A;
        else if (sts.a_last) state_nxt = rrds_pkg::ST_SRCH_W;
      end
      rrds_pkg::ST_SRCH_W: begin
        if (sts.w_hit)       state_nxt = rrds_pkg::ST_SHIFT_W;
        else if (sts.w_last) state_nxt = rrds_pkg::ST_OUT;
      end
      rrds_pkg::ST_SHIFT_A: if (sts.a_last) state_nxt = rrds_pkg::ST_OUT;
      rrds_pkg::ST_SHIFT_W: if (sts.w_last) state_nxt = rrds_pkg::ST_OUT;
      rrds_pkg::ST_OUT:     if (!out_stall) state_nxt = rrds_pkg::ST_IDLE;
      default:              state_nxt = rrds_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    unique case (state_r)
      rrds_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      rrds_pkg::ST_DECIDE: cmd.decide = 1'b1;
      rrds_pkg::ST_SRCH_A: begin
        cmd.srch_a = 1'b1;
      end
      rrds_pkg::ST_SRCH_W: begin
        cmd.srch_w    = 1'b1;
        cmd.not_found = !sts.w_hit && sts.w_last;
      end
      rrds_pkg::ST_SHIFT_A: begin
        cmd.shift_a  = !sts.a_last;
        cmd.finish_a = sts.a_last;
      end
      rrds_pkg::ST_SHIFT_W: begin
        cmd.shift_w  = !sts.w_last;
        cmd.finish_w = sts.w_last;
      end
      rrds_pkg::ST_OUT: out_valid = 1'b1;
      default: ;
    endcase
  end
endmodule
`default_nettype wire

### rtl/core/rrds_dp.sv
// task tables, counters and result register
`default_nettype none
module rrds_dp #(
  parameter int MAX_ENTRIES = rrds_pkg::MAX_ENTRIES_DEF,
  parameter int WAIT_DEPTH  = rrds_pkg::WAIT_DEPTH_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire rrds_pkg::cmd_t cmd,
  output rrds_pkg::sts_t      sts,
  input  wire logic [1:0]     in_operation,
  input  wire logic [15:0]    in_pid,
  input  wire logic [15:0]    in_work_time,
  input  wire logic [15:0]    quantum,
  input  wire logic [7:0]     demote_limit,
  input  wire logic [4:0]     active_limit,
  output logic [3:0]          out_event_res,
  output logic [15:0]         out_task_id,
  output logic [15:0]         out_run_time,
  output logic [15:0]         out_remaining
);
  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int WW = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
  localparam int AC = $clog2(MAX_ENTRIES + 1);
  localparam int WC = $clog2(WAIT_DEPTH + 1);

  logic [15:0] a_id_r  [MAX_ENTRIES];
  logic [15:0] a_rem_r [MAX_ENTRIES];
  logic [7:0]  a_sl_r  [MAX_ENTRIES];
  logic [15:0] w_id_r  [WAIT_DEPTH];
  logic [15:0] w_rem_r [WAIT_DEPTH];
  logic [AC-1:0] a_cnt_r;
  logic [WC-1:0] w_cnt_r;
  logic [AW-1:0] rot_r;
  logic [15:0]   next_id_r;
  logic [1:0]    op_r;
  logic [15:0]   pid_r, work_r;
  logic [AC-1:0] idx_r;     // scan / shift pointer (active)
  logic [WC-1:0] widx_r;    // scan / shift pointer (waiting)
  logic [AW-1:0] pos_r;     // removed active position
  logic          rot_adv_r; // dispatch removal: no backstep on rotation

  // rotation point clamp and dispatch arithmetic
  logic [AW-1:0] pos;
  logic [15:0]   cur_rem;
  logic [7:0]    cur_sl, sl_inc;
  logic          expire;
  logic [AC-1:0] cap;
  assign pos     = (AC'(rot_r) < a_cnt_r) ? rot_r : '0;
  assign cur_rem = a_rem_r[pos];
  assign cur_sl  = a_sl_r[pos];
  assign sl_inc  = (cur_sl == 8'hFF) ? cur_sl : cur_sl + 8'd1;
  assign expire  = cur_rem > quantum;
  assign cap     = ({27'd0, active_limit} > 32'(MAX_ENTRIES)) ? AC'(MAX_ENTRIES)
                                                              : AC'(active_limit);

  logic a_hit, w_hit;
  assign a_hit = (idx_r < a_cnt_r) && (a_id_r[idx_r[AW-1:0]] == pid_r);
  assign w_hit = (widx_r < w_cnt_r) && (w_id_r[widx_r[WW-1:0]] == pid_r);

  always_comb begin
    sts.is_kill = (op_r == rrds_pkg::OP_KILL);
    sts.remove  = (op_r == rrds_pkg::OP_DISPATCH) && (a_cnt_r != '0) &&
                  (!expire || sl_inc >= demote_limit);
    sts.a_hit   = a_hit;
    sts.w_hit   = w_hit;
    sts.a_last  = (idx_r + AC'(1) >= a_cnt_r);
    sts.w_last  = (widx_r + WC'(1) >= w_cnt_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_cnt_r   <= '0;
      w_cnt_r   <= '0;
      rot_r     <= '0;
      next_id_r <= '0;
      op_r      <= rrds_pkg::OP_NONE;
    end else begin
      if (cmd.load) begin
        op_r   <= in_operation;
        pid_r  <= in_pid;
        work_r <= in_work_time;
        idx_r  <= '0;
        widx_r <= '0;
      end
      if (cmd.decide) begin
        out_run_time <= '0;
        unique case (op_r)
          rrds_pkg::OP_ADMIT: begin
            next_id_r     <= next_id_r + 16'd1;
            out_task_id   <= next_id_r;
            out_remaining <= work_r;
            if (a_cnt_r < cap) begin
              a_id_r[a_cnt_r[AW-1:0]]  <= next_id_r;
              a_rem_r[a_cnt_r[AW-1:0]] <= work_r;
              a_sl_r[a_cnt_r[AW-1:0]]  <= '0;
              a_cnt_r       <= a_cnt_r + AC'(1);
              out_event_res <= rrds_pkg::EV_ADMITTED;
            end else if (w_cnt_r < WC'(WAIT_DEPTH)) begin
              w_id_r[w_cnt_r[WW-1:0]]  <= next_id_r;
              w_rem_r[w_cnt_r[WW-1:0]] <= work_r;
              w_cnt_r       <= w_cnt_r + WC'(1);
              out_event_res <= rrds_pkg::EV_WAITING;
            end else begin
              out_event_res <= rrds_pkg::EV_REJECTED;
            end
          end
          rrds_pkg::OP_KILL: begin
            out_task_id   <= pid_r;
            out_remaining <= '0;
          end
          rrds_pkg::OP_DISPATCH: begin
            if (a_cnt_r == '0) begin
              out_event_res <= rrds_pkg::EV_IDLE;
              out_task_id   <= '0;
              out_remaining <= '0;
            end else begin
              out_task_id <= a_id_r[pos];
              pos_r       <= pos;
              idx_r       <= AC'(pos);
              rot_r       <= pos;
              rot_adv_r   <= 1'b1;
              if (expire) begin
                out_run_time  <= quantum;
                out_remaining <= cur_rem - quantum;
                a_rem_r[pos]  <= cur_rem - quantum;
                a_sl_r[pos]   <= sl_inc;
                if (sl_inc >= demote_limit) begin
                  out_event_res <= rrds_pkg::EV_DEMOTED;
                end else begin
                  out_event_res <= rrds_pkg::EV_EXPIRED;
                  rot_r <= (AC'(pos) + AC'(1) >= a_cnt_r) ? '0 : pos + AW'(1);
                end
              end else begin
                out_run_time  <= cur_rem;
                out_remaining <= '0;
                out_event_res <= rrds_pkg::EV_FINISHED;
              end
            end
          end
          default: begin
            out_event_res <= rrds_pkg::EV_IDLE;
            out_task_id   <= '0;
            out_remaining <= '0;
          end
        endcase
      end
      if (cmd.srch_a) begin
        if (a_hit) begin
          out_event_res <= rrds_pkg::EV_KILL_ACT;
          out_remaining <= a_rem_r[idx_r[AW-1:0]];
          pos_r         <= idx_r[AW-1:0];
          rot_adv_r     <= 1'b0;
        end else begin
          idx_r <= idx_r + AC'(1);
        end
      end
      if (cmd.srch_w) begin
        if (w_hit) begin
          out_event_res <= rrds_pkg::EV_KILL_WAIT;
          out_remaining <= w_rem_r[widx_r[WW-1:0]];
        end else begin
          widx_r <= widx_r + WC'(1);
        end
      end
      if (cmd.not_found) out_event_res <= rrds_pkg::EV_NOT_FOUND;
      if (cmd.shift_a) begin
        a_id_r[idx_r[AW-1:0]]  <= a_id_r[idx_r[AW-1:0] + AW'(1)];
        a_rem_r[idx_r[AW-1:0]] <= a_rem_r[idx_r[AW-1:0] + AW'(1)];
        a_sl_r[idx_r[AW-1:0]]  <= a_sl_r[idx_r[AW-1:0] + AW'(1)];
        idx_r <= idx_r + AC'(1);
      end
      if (cmd.shift_w) begin
        w_id_r[widx_r[WW-1:0]]  <= w_id_r[widx_r[WW-1:0] + WW'(1)];
        w_rem_r[widx_r[WW-1:0]] <= w_rem_r[widx_r[WW-1:0] + WW'(1)];
        widx_r <= widx_r + WC'(1);
      end
      if (cmd.finish_a) begin
        logic [AW-1:0] r;
        r = rot_r;
        a_cnt_r <= a_cnt_r - AC'(1);
        if (!rot_adv_r && pos_r < rot_r) r = rot_r - AW'(1);
        if (AC'(r) >= a_cnt_r - AC'(1)) r = '0;
        rot_r <= r;
      end
      if (cmd.finish_w) w_cnt_r <= w_cnt_r - WC'(1);
    end
  end
endmodule
`default_nettype wire

### rtl/core/round_robin_demoting_scheduler.sv
// top level of the round robin demoting scheduler
//
// channel  direction  handshake          payload
// in       input      in_valid/in_stall  in_operation, in_pid, in_work_time
// out      output     out_valid/out_stall out_event_res, out_task_id, out_run_time, out_remaining
// cfg      input      apb write/read     quantum, demote_limit, active_limit
//
// an item passes through accept, decide and result, in that order
// a removal compacts the table one entry a cycle
// a kill scans one entry a cycle, active then waiting
// reset is synchronous and clears counters and control; tables need no clearing
// a stalled result holds in the output register and blocks the next transfer
`default_nettype none
module round_robin_demoting_scheduler #(
  parameter int MAX_ENTRIES = rrds_pkg::MAX_ENTRIES_DEF,
  parameter int WAIT_DEPTH  = rrds_pkg::WAIT_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_operation,
  input  wire logic [15:0] in_pid,
  input  wire logic [15:0] in_work_time,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [3:0]       out_event_res,
  output logic [15:0]      out_task_id,
  output logic [15:0]      out_run_time,
  output logic [15:0]      out_remaining,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  logic [15:0] quantum_r;
  logic [7:0]  demote_r;
  logic [4:0]  active_r;
  rrds_pkg::cmd_t cmd;
  rrds_pkg::sts_t sts;

  assign pready = 1'b1;

  // register writes on the access cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quantum_r <= 16'd100;
      demote_r  <= 8'd3;
      active_r  <= 5'd8;
    end else if (psel && penable && pwrite) begin
      unique case (paddr)
        rrds_pkg::CFG_QUANTUM: quantum_r <= pwdata[15:0];
        rrds_pkg::CFG_DEMOTE:  demote_r  <= pwdata[7:0];
        rrds_pkg::CFG_ACTIVE:  active_r  <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr)
      rrds_pkg::CFG_QUANTUM: prdata = {16'd0, quantum_r};
      rrds_pkg::CFG_DEMOTE:  prdata = {24'd0, demote_r};
      rrds_pkg::CFG_ACTIVE:  prdata = {27'd0, active_r};
      default:               prdata = '0;
    endcase
  end

  rrds_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall, .sts, .cmd
  );

  rrds_dp #(.MAX_ENTRIES(MAX_ENTRIES), .WAIT_DEPTH(WAIT_DEPTH)) u_dp (
    .clk, .rst_n, .cmd, .sts, .in_operation, .in_pid, .in_work_time,
    .quantum(quantum_r), .demote_limit(demote_r), .active_limit(active_r),
    .out_event_res, .out_task_id, .out_run_time, .out_remaining
  );

  // no input transfer while a result is pending
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("input taken while result pending");
  // the decide state always lies between an accepted transfer and its result
  a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> !out_valid) else $error("result too early");
  // result event code stays in range
  a_ev_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_event_res <= rrds_pkg::EV_IDLE)) else $error("bad event code");
endmodule
`default_nettype wire

### dv/tb_top.sv
// testbench for the round robin demoting scheduler: random and directed requests checked in order
`timescale 1ns / 1ps
`default_nettype none

class task_table_board;
  // task table mirror
  logic [15:0] quantum_q;
  logic [7:0]  demote_q;
  logic [4:0]  limit_q;
  logic [15:0] act_id[16];
  logic [15:0] act_rem[16];
  logic [7:0]  act_sl[16];
  int          act_n;
  int          rot;
  logic [15:0] wt_id[16];
  logic [15:0] wt_rem[16];
  int          wt_n;
  logic [15:0] id_next;
  logic [51:0] pending[$];
  int          mismatches;
  int          checked;

  function new();
    quantum_q = 16'd100;
    demote_q = 8'd3;
    limit_q = 5'd8;
    act_n = 0;
    rot = 0;
    wt_n = 0;
    id_next = 16'd0;
    mismatches = 0;
    checked = 0;
  endfunction

  function void remove_active(int pos);
    for (int i = pos; i + 1 < act_n; i++) begin
      act_id[i] = act_id[i+1];
      act_rem[i] = act_rem[i+1];
      act_sl[i] = act_sl[i+1];
    end
    act_n--;
    if (pos < rot) rot--;
    if (rot >= act_n) rot = 0;
  endfunction

  function void push(rrds_pkg::ev_t ev, logic [15:0] id, logic [15:0] rt, logic [15:0] rm);
    pending.insert(pending.size(), {ev, id, rt, rm});
  endfunction

  // note one accepted request and queue its expected event
  function void note_request(logic [1:0] op, logic [15:0] pid, logic [15:0] work);
    int cap;
    int pos;
    logic [15:0] id;
    logic [15:0] rm;
    logic [7:0] sl;
    bit hit;
    hit = 0;
    if (op == rrds_pkg::OP_ADMIT) begin
      id = id_next;
      id_next = id_next + 16'd1;
      cap = (limit_q < 16) ? limit_q : 16;
      if (act_n < cap) begin
        act_id[act_n] = id;
        act_rem[act_n] = work;
        act_sl[act_n] = 8'd0;
        act_n++;
        push(rrds_pkg::EV_ADMITTED, id, 16'd0, work);
      end else if (wt_n < 16) begin
        wt_id[wt_n] = id;
        wt_rem[wt_n] = work;
        wt_n++;
        push(rrds_pkg::EV_WAITING, id, 16'd0, work);
      end else push(rrds_pkg::EV_REJECTED, id, 16'd0, work);
    end else if (op == rrds_pkg::OP_KILL) begin
      for (int i = 0; i < act_n && !hit; i++)
        if (act_id[i] == pid) begin
          rm = act_rem[i];
          remove_active(i);
          push(rrds_pkg::EV_KILL_ACT, pid, 16'd0, rm);
          hit = 1;
        end
      for (int i = 0; i < wt_n && !hit; i++)
        if (wt_id[i] == pid) begin
          rm = wt_rem[i];
          for (int j = i; j + 1 < wt_n; j++) begin
            wt_id[j] = wt_id[j+1];
            wt_rem[j] = wt_rem[j+1];
          end
          wt_n--;
          push(rrds_pkg::EV_KILL_WAIT, pid, 16'd0, rm);
          hit = 1;
        end
      if (!hit) push(rrds_pkg::EV_NOT_FOUND, pid, 16'd0, 16'd0);
    end else if (op == rrds_pkg::OP_DISPATCH && act_n > 0) begin
      pos = (rot < act_n) ? rot : 0;
      id = act_id[pos];
      rm = act_rem[pos];
      rot = pos;
      if (rm > quantum_q) begin
        rm = rm - quantum_q;
        sl = act_sl[pos];
        if (sl != 8'hff) sl++;
        act_rem[pos] = rm;
        act_sl[pos] = sl;
        if (sl >= demote_q) begin
          remove_active(pos);
          push(rrds_pkg::EV_DEMOTED, id, quantum_q, rm);
        end else begin
          rot = pos + 1;
          if (rot >= act_n) rot = 0;
          push(rrds_pkg::EV_EXPIRED, id, quantum_q, rm);
        end
      end else begin
        remove_active(pos);
        push(rrds_pkg::EV_FINISHED, id, rm, 16'd0);
      end
    end else push(rrds_pkg::EV_IDLE, 16'd0, 16'd0, 16'd0);
  endfunction

  // compare one event transfer with the oldest expectation
  function void check_event(logic [3:0] ev, logic [15:0] id, logic [15:0] rt, logic [15:0] rm);
    logic [51:0] exp_ev;
    checked++;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected event %0d id %0d", ev, id);
      return;
    end
    exp_ev = pending.pop_front();
    if (exp_ev !== {ev, id, rt, rm}) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: exp ev %0d id %0d run %0d rem %0d, got ev %0d id %0d run %0d rem %0d",
                 exp_ev[51:48], exp_ev[47:32], exp_ev[31:16], exp_ev[15:0], ev, id, rt, rm);
    end
  endfunction
endclass

module tb_top;
  localparam int STALL_LIMIT = 4000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_operation = '0;
  logic [15:0] in_pid = '0;
  logic [15:0] in_work_time = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [3:0]  out_event_res;
  logic [15:0] out_task_id;
  logic [15:0] out_run_time;
  logic [15:0] out_remaining;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  task_table_board board;
  int  idle_cycles = 0;
  int  sent = 0;
  bit  sink_on = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  round_robin_demoting_scheduler u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_operation(in_operation), .in_pid(in_pid), .in_work_time(in_work_time),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_event_res(out_event_res), .out_task_id(out_task_id),
    .out_run_time(out_run_time), .out_remaining(out_remaining),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // sample both transfers at the rising edge, feed the scoreboard
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) board.note_request(in_operation, in_pid, in_work_time);
      if (out_valid && !out_stall)
        board.check_event(out_event_res, out_task_id, out_run_time, out_remaining);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // receiver stall pattern, driven at the falling edge
  initial begin
    int n;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!sink_on) out_stall <= 1'b0;
      else begin
        n = gap_len();
        if (n > 0) begin
          out_stall <= 1'b1;
          repeat (n) @(negedge clk);
        end
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_request(logic [1:0] op, logic [15:0] pid, logic [15:0] work, bit gaps);
    int n;
    n = gaps ? gap_len() : 0;
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_pid <= pid;
    in_work_time <= work;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (board.pending.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  // setup then access phase; the register takes the value at the access edge
  task automatic write_reg(logic [3:0] addr, logic [31:0] data);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (addr)
      rrds_pkg::CFG_QUANTUM: board.quantum_q = data[15:0];
      rrds_pkg::CFG_DEMOTE:  board.demote_q = data[7:0];
      default:               board.limit_q = data[4:0];
    endcase
  endtask

  // pick an id that is likely live, else a random one
  function automatic logic [15:0] pick_pid();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4 && board.act_n > 0) return board.act_id[$urandom_range(0, board.act_n - 1)];
    if (r < 7 && board.wt_n > 0) return board.wt_id[$urandom_range(0, board.wt_n - 1)];
    if (r < 8) return board.id_next - 16'd1;
    return 16'($urandom());
  endfunction

  task automatic random_phase(int count);
    int r;
    logic [1:0] op;
    logic [15:0] work;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      if (r < 38) op = rrds_pkg::OP_ADMIT;
      else if (r < 58) op = rrds_pkg::OP_KILL;
      else if (r < 96) op = rrds_pkg::OP_DISPATCH;
      else op = rrds_pkg::OP_NONE;
      r = $urandom_range(0, 9);
      work = (r < 6) ? 16'($urandom_range(0, 400)) : 16'($urandom());
      send_request(op, pick_pid(), work, 1'b1);
    end
  endtask

  initial begin
    board = new();
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed part, with reset register values
    send_request(rrds_pkg::OP_DISPATCH, 16'd0, 16'd0, 1'b0);   // empty table gives idle
    send_request(rrds_pkg::OP_KILL, 16'hffff, 16'd0, 1'b0);    // not found
    send_request(rrds_pkg::OP_NONE, 16'hffff, 16'hffff, 1'b0); // unknown operation
    send_request(rrds_pkg::OP_ADMIT, 16'd0, 16'd0, 1'b0);      // zero work
    send_request(rrds_pkg::OP_ADMIT, 16'hffff, 16'hffff, 1'b0);
    send_request(rrds_pkg::OP_ADMIT, 16'd0, 16'd250, 1'b0);
    send_request(rrds_pkg::OP_ADMIT, 16'd0, 16'd100, 1'b0);    // exactly one quantum
    repeat (6) send_request(rrds_pkg::OP_DISPATCH, 16'd0, 16'd0, 1'b0);
    send_request(rrds_pkg::OP_KILL, 16'd1, 16'd0, 1'b0);       // kill at the rotation point
    // fill active, spill to waiting
    repeat (8) send_request(rrds_pkg::OP_ADMIT, 16'd0, 16'h5555, 1'b0);
    // kill a waiting task
    send_request(rrds_pkg::OP_KILL, board.id_next - 16'd1, 16'd0, 1'b0);
    drain();

    // zero settings: no active slots, zero quantum, demote on first slice
    write_reg(rrds_pkg::CFG_QUANTUM, 32'd0);
    write_reg(rrds_pkg::CFG_DEMOTE, 32'd0);
    write_reg(rrds_pkg::CFG_ACTIVE, 32'd0);
    sink_on = 1'b1;
    random_phase(60);
    drain();

    // pressure: admits until both tables are full and rejecting
    write_reg(rrds_pkg::CFG_ACTIVE, 32'd16);
    write_reg(rrds_pkg::CFG_QUANTUM, 32'd1);
    repeat (40) send_request(rrds_pkg::OP_ADMIT, 16'd0, 16'($urandom()), 1'b1);
    drain();

    // several settings, including extremes and a cap above table size
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin write_reg(rrds_pkg::CFG_QUANTUM, 32'd65535);
                 write_reg(rrds_pkg::CFG_DEMOTE, 32'd255);
                 write_reg(rrds_pkg::CFG_ACTIVE, 32'd31); end
        1: begin write_reg(rrds_pkg::CFG_QUANTUM, 32'd100);
                 write_reg(rrds_pkg::CFG_DEMOTE, 32'd3);
                 write_reg(rrds_pkg::CFG_ACTIVE, 32'd8); end
        2: begin write_reg(rrds_pkg::CFG_QUANTUM, 32'd1);
                 write_reg(rrds_pkg::CFG_DEMOTE, 32'd1);
                 write_reg(rrds_pkg::CFG_ACTIVE, 32'd1); end
        default: begin
          write_reg(rrds_pkg::CFG_QUANTUM,
                    $urandom_range(0, 65535) & ($urandom_range(0, 1) ? 32'h1ff : 32'hffff));
          write_reg(rrds_pkg::CFG_DEMOTE,
                    $urandom_range(0, 255) & ($urandom_range(0, 1) ? 32'h7 : 32'hff));
          write_reg(rrds_pkg::CFG_ACTIVE, $urandom_range(0, 31));
        end
      endcase
      random_phase(200);
      drain();
    end

    // short closing phase with a small active table
    write_reg(rrds_pkg::CFG_ACTIVE, 32'd4);
    random_phase(50);
    drain();

    $display("covered %0d requests and %0d events over several register settings", sent,
             board.checked);
    if (board.mismatches == 0 && board.pending.size() == 0)
      $display("Testbench completed without errors");
    else begin
      $display("mismatches %0d, left over %0d", board.mismatches, board.pending.size());
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
`default_nettype wire
